// ===== rtl/tun_pkg.sv =====
// Package for the triangle unit-normal block: widths, pipeline layout and stage types.
// Used by every file in rtl/.
package tun_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int LANES      = 3;
  localparam int EDGE_W     = COORD_WIDTH + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int N_W        = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int K_W        = NORMAL_FRAC_BITS + 2;
  localparam int OUT_W      = K_W;
  localparam int ROOT_STEPS = K_W;
  localparam int ROOT_SHIFT = 2 * (K_W - 1);
  localparam int ACC_W      = SUM_W + ROOT_SHIFT + 4;

  // pipeline stage numbers
  localparam int ST_EDGE  = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_NORM  = 2;
  localparam int ST_SQ    = 3;
  localparam int ST_SUM   = 4;
  localparam int ST_ROOT0 = 5;
  localparam int ST_OUT   = ST_ROOT0 + ROOT_STEPS;
  localparam int NST      = ST_OUT + 1;

  localparam logic [K_W-1:0]   BIT_TOP = K_W'(1) << (K_W - 1);
  localparam logic [OUT_W-1:0] NRM_ONE = OUT_W'(1) << NORMAL_FRAC_BITS;

  typedef struct packed {
    logic [ACC_W-1:0] d;
    logic [ACC_W-1:0] p;
    logic [K_W-1:0]   k;
    logic             neg;
  } root_lane_t;

  typedef struct packed {
    root_lane_t [LANES-1:0] lane;
    logic [ACC_W-1:0]       q;
    logic [K_W-1:0]         bit_sel;
    logic                   zero;
  } root_t;

endpackage

// ===== rtl/tun_if.sv =====
// Channel interfaces of the triangle unit-normal block (vertex input, normal output).
// Depends on tun_pkg.
interface tun_in_if import tun_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
  logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
  logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;

  modport source(output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 input ready);
  modport sink(input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
               output ready);
endinterface

interface tun_out_if import tun_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;

  modport source(output valid, normal_x, normal_y, normal_z, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== rtl/tun_cross.sv =====
// Edge vectors, partial products and cross product (three pipeline stages).
// Depends on tun_pkg.
module tun_cross import tun_pkg::*; (
  input  logic                          clk,
  input  logic [2:0]                    en,
  input  logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z,
  input  logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z,
  input  logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z,
  output logic [LANES-1:0][MAG_W-1:0]   mag,
  output logic [LANES-1:0]              neg
);

  logic signed [EDGE_W-1:0] a_r  [LANES];
  logic signed [EDGE_W-1:0] b_r  [LANES];
  logic signed [PROD_W-1:0] pl_r [LANES];
  logic signed [PROD_W-1:0] pr_r [LANES];
  logic signed [N_W-1:0]    n_nxt [LANES];
  logic [MAG_W-1:0]         mag_r [LANES];
  logic                     neg_r [LANES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r[0] <= EDGE_W'(p0_x) - EDGE_W'(p1_x);
      a_r[1] <= EDGE_W'(p0_y) - EDGE_W'(p1_y);
      a_r[2] <= EDGE_W'(p0_z) - EDGE_W'(p1_z);
      b_r[0] <= EDGE_W'(p2_x) - EDGE_W'(p1_x);
      b_r[1] <= EDGE_W'(p2_y) - EDGE_W'(p1_y);
      b_r[2] <= EDGE_W'(p2_z) - EDGE_W'(p1_z);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pl_r[0] <= PROD_W'(a_r[1]) * PROD_W'(b_r[2]);
      pr_r[0] <= PROD_W'(a_r[2]) * PROD_W'(b_r[1]);
      pl_r[1] <= PROD_W'(a_r[2]) * PROD_W'(b_r[0]);
      pr_r[1] <= PROD_W'(a_r[0]) * PROD_W'(b_r[2]);
      pl_r[2] <= PROD_W'(a_r[0]) * PROD_W'(b_r[1]);
      pr_r[2] <= PROD_W'(a_r[1]) * PROD_W'(b_r[0]);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      n_nxt[i] = N_W'(pl_r[i]) - N_W'(pr_r[i]);
    end
  end

  // sign and magnitude; magnitude never exceeds 2^(MAG_W-1)
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < LANES; i++) begin
        neg_r[i] <= n_nxt[i][N_W-1];
        mag_r[i] <= n_nxt[i][N_W-1] ? MAG_W'(-n_nxt[i]) : MAG_W'(n_nxt[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag[i] = mag_r[i];
      neg[i] = neg_r[i];
    end
  end

endmodule

// ===== rtl/tun_square.sv =====
// Squares of the cross product components, squared length and root-search set-up.
// Depends on tun_pkg.
module tun_square import tun_pkg::*; (
  input  logic                        clk,
  input  logic [1:0]                  en,
  input  logic [LANES-1:0][MAG_W-1:0] mag,
  input  logic [LANES-1:0]            neg,
  output root_t                       root
);

  logic [SQ_W-1:0]  sq_r  [LANES];
  logic             neg_r [LANES];
  logic             zero_r;
  logic [SUM_W-1:0] sum;
  root_t            root_nxt;
  root_t            root_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        sq_r[i]  <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
        neg_r[i] <= neg[i];
      end
      zero_r <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
    end
  end

  // remainder starts at a^2 * 2^ROOT_SHIFT, trial term at S * 2^ROOT_SHIFT
  always_comb begin
    sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    root_nxt.q       = ACC_W'(sum) << ROOT_SHIFT;
    root_nxt.bit_sel = BIT_TOP;
    root_nxt.zero    = zero_r;
    for (int i = 0; i < LANES; i++) begin
      root_nxt.lane[i].d   = ACC_W'(sq_r[i]) << ROOT_SHIFT;
      root_nxt.lane[i].p   = '0;
      root_nxt.lane[i].k   = '0;
      root_nxt.lane[i].neg = neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      root_r <= root_nxt;
    end
  end

  assign root = root_r;

endmodule

// ===== rtl/tun_root_step.sv =====
// One bit of k = floor(2^15 * |N_i| / |N|) per lane, found by shift-and-subtract.
// Depends on tun_pkg.
module tun_root_step import tun_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  root_t root_in,
  output root_t root_out
);

  logic [ACC_W-1:0] trial [LANES];
  logic [ACC_W:0]   diff  [LANES];
  logic             take  [LANES];
  root_t            root_nxt;
  root_t            root_r;

  // p = k*S*2^(j+1), q = S*2^(2j); (k+2^j)^2 S fits iff p+q <= remainder
  always_comb begin
    root_nxt         = root_in;
    root_nxt.q       = root_in.q >> 2;
    root_nxt.bit_sel = root_in.bit_sel >> 1;
    for (int i = 0; i < LANES; i++) begin
      trial[i] = root_in.lane[i].p + root_in.q;
      diff[i]  = {1'b0, root_in.lane[i].d} - {1'b0, trial[i]};
      take[i]  = !diff[i][ACC_W];
      if (take[i]) begin
        root_nxt.lane[i].d = diff[i][ACC_W-1:0];
        root_nxt.lane[i].p = (root_in.lane[i].p >> 1) + root_in.q;
        root_nxt.lane[i].k = root_in.lane[i].k | root_in.bit_sel;
      end else begin
        root_nxt.lane[i].p = root_in.lane[i].p >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
    end
  end

  assign root_out = root_r;

endmodule

// ===== rtl/tun_out.sv =====
// Final rounding, clamp, sign and degenerate case; holds the output register.
// Depends on tun_pkg.
module tun_out import tun_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  root_t                       root,
  output logic [LANES-1:0][OUT_W-1:0] normal
);

  logic [K_W:0]     k_inc [LANES];
  logic [OUT_W-1:0] m     [LANES];
  logic [OUT_W-1:0] val   [LANES];
  logic [OUT_W-1:0] normal_r [LANES];

  // k is twice the quotient, so (k+1)/2 rounds half away from zero
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      k_inc[i] = {1'b0, root.lane[i].k} + (K_W+1)'(1);
      m[i]     = OUT_W'(k_inc[i][K_W:1]);
      if (m[i] > NRM_ONE) begin
        m[i] = NRM_ONE;
      end
      if (root.zero) begin
        val[i] = '0;
      end else begin
        val[i] = root.lane[i].neg ? OUT_W'(-m[i]) : m[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        normal_r[i] <= val[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      normal[i] = normal_r[i];
    end
  end

endmodule

// ===== rtl/triangle_unit_normal.sv =====
// Triangle unit normal, top level: pipeline control and stage instances.
// Depends on tun_pkg, tun_if, tun_cross, tun_square, tun_root_step, tun_out.
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        p0_x..p2_z, signed Q8.8
//  out_chan  out  valid/ready        normal_x/y/z, signed Q1.14
//
// 22 register stages: edges, products, cross product, squares, sum, 16 root
// steps (one quotient bit each), output. One triangle per cycle while the output
// is not stalled. Each stage holds its item while the next is full and held;
// empty stages fill behind a stalled output, so nothing is dropped or repeated.
// Reset clears valid bits only.
module triangle_unit_normal import tun_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  tun_in_if.sink   in_chan,
  tun_out_if.source out_chan
);

  logic [NST-1:0]              valid_r;
  logic [NST-1:0]              valid_nxt;
  logic [NST-1:0]              en;
  logic [LANES-1:0][MAG_W-1:0] mag;
  logic [LANES-1:0]            neg;
  logic [LANES-1:0][OUT_W-1:0] normal;
  root_t                       root_c [ROOT_STEPS+1];

  always_comb begin
    en[NST-1] = !valid_r[NST-1] || out_chan.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < NST; i++) begin
      if (en[i]) begin
        valid_nxt[i] = (i == 0) ? in_chan.valid : valid_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_chan.ready = en[ST_EDGE];

  tun_cross u_cross (
    .clk  (clk),
    .en   (en[ST_NORM:ST_EDGE]),
    .p0_x (in_chan.p0_x), .p0_y (in_chan.p0_y), .p0_z (in_chan.p0_z),
    .p1_x (in_chan.p1_x), .p1_y (in_chan.p1_y), .p1_z (in_chan.p1_z),
    .p2_x (in_chan.p2_x), .p2_y (in_chan.p2_y), .p2_z (in_chan.p2_z),
    .mag  (mag),
    .neg  (neg)
  );

  tun_square u_square (
    .clk  (clk),
    .en   (en[ST_SUM:ST_SQ]),
    .mag  (mag),
    .neg  (neg),
    .root (root_c[0])
  );

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    tun_root_step u_step (
      .clk      (clk),
      .en       (en[ST_ROOT0+g]),
      .root_in  (root_c[g]),
      .root_out (root_c[g+1])
    );
  end

  tun_out u_out (
    .clk    (clk),
    .en     (en[ST_OUT]),
    .root   (root_c[ROOT_STEPS]),
    .normal (normal)
  );

  assign out_chan.valid    = valid_r[ST_OUT];
  assign out_chan.normal_x = normal[0];
  assign out_chan.normal_y = normal[1];
  assign out_chan.normal_z = normal[2];

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> valid_r[ST_EDGE])
    else $error("accepted item not captured");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ST_OUT-1] && !en[ST_OUT] |=> valid_r[ST_OUT-1])
    else $error("item lost in stalled pipeline");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ($signed(out_chan.normal_x) <= 16'sd16384)
      && ($signed(out_chan.normal_x) >= -16'sd16384)
      && ($signed(out_chan.normal_y) <= 16'sd16384)
      && ($signed(out_chan.normal_y) >= -16'sd16384)
      && ($signed(out_chan.normal_z) <= 16'sd16384)
      && ($signed(out_chan.normal_z) >= -16'sd16384))
    else $error("normal component out of range");
`endif

endmodule
